// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the ternary weight packer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TWP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define TWP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/twp_pkg.sv =====
// ---------------------------------------------------------------------------
// twp_pkg
// Types, constants and helpers for the ternary weight packer.
// ---------------------------------------------------------------------------
package twp_pkg;

    localparam int MAX_ROWS    = 4096;
    localparam int MAX_ROW_LEN = 16384;

    localparam int ROW_W  = 12;     // row counter
    localparam int COL_W  = 14;     // column counter
    localparam int GRP_W  = 13;     // group counter, holds a full row of groups
    localparam int RCNT_W = 13;     // row_count register
    localparam int LEN_W  = 15;     // row_length register
    localparam int THR_W  = 31;     // zero_threshold register
    localparam int ADDR_W = 24;
    localparam int N20_W  = 10;     // row_length / 20
    localparam int N5_W   = 12;     // five-trit groups per row

    // x / 5 == (x * RECIP5) >> RECIP5_SHIFT for x below 2^16
    localparam logic [15:0] RECIP5       = 16'hCCCD;
    localparam int          RECIP5_SHIFT = 18;

    localparam logic [30:0] FP_INF_MAG = 31'h7F80_0000;

    typedef enum logic [2:0] {
        MODE_FOUR_PLAIN = 3'd0,
        MODE_FOUR_X4    = 3'd1,
        MODE_FOUR_X8    = 3'd2,
        MODE_FIVE_PLAIN = 3'd3,
        MODE_FIVE_X2    = 3'd4
    } layout_t;

    typedef enum logic [1:0] {
        REG_LAYOUT_MODE    = 2'd0,
        REG_ROW_COUNT      = 2'd1,
        REG_ROW_LENGTH     = 2'd2,
        REG_ZERO_THRESHOLD = 2'd3
    } reg_idx_t;

    typedef logic [1:0] trit_t;
    localparam trit_t TRIT_NEG  = 2'd0;
    localparam trit_t TRIT_ZERO = 2'd1;
    localparam trit_t TRIT_POS  = 2'd2;

    // Effective configuration seen by the datapath
    typedef struct packed {
        layout_t            mode;
        logic               five;
        logic [RCNT_W-1:0]  rows;
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   covered;
        logic [N5_W-1:0]    n5;
        logic [GRP_W-1:0]   total;
        logic [THR_W-1:0]   threshold;
    } cfg_t;

    function automatic logic [7:0] pow3(input logic [2:0] pos);
        logic [7:0] p;
        unique case (pos)
            3'd0:    p = 8'd1;
            3'd1:    p = 8'd3;
            3'd2:    p = 8'd9;
            3'd3:    p = 8'd27;
            3'd4:    p = 8'd81;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/twp_cfg.sv =====
// ---------------------------------------------------------------------------
// twp_cfg
// APB register file; derives the per-row group counts at write time.
// ---------------------------------------------------------------------------
module twp_cfg
    import twp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [2:0]        mode_reg;
    logic [RCNT_W-1:0] rows_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [THR_W-1:0]  thr_reg;
    logic [RCNT_W-1:0] rows_eff_reg, rows_eff_next;
    logic [LEN_W-1:0]  len_eff_reg, len_eff_next;
    logic [N20_W-1:0]  n20_reg, n20_next;
    logic [2:0]        r4_reg, r4_next;

    logic              wr;
    reg_idx_t          idx;
    logic [RCNT_W-1:0] rows_in;
    logic [LEN_W-1:0]  len_in;
    logic [28:0]       recip_prod;
    logic [LEN_W-1:0]  n20_x20;
    logic [4:0]        rem20;
    layout_t           mode_eff;
    logic [N5_W-1:0]   n5_all;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    assign rows_in = pwdata[RCNT_W-1:0];
    assign len_in  = pwdata[LEN_W-1:0];

    always_comb
    begin
        if (rows_in == '0)
            rows_eff_next = RCNT_W'(1);
        else if (rows_in > RCNT_W'(MAX_ROWS))
            rows_eff_next = RCNT_W'(MAX_ROWS);
        else
            rows_eff_next = rows_in;

        if (len_in == '0)
            len_eff_next = LEN_W'(1);
        else if (len_in > LEN_W'(MAX_ROW_LEN))
            len_eff_next = LEN_W'(MAX_ROW_LEN);
        else
            len_eff_next = len_in;
    end

    // len / 20 as (len / 4) / 5, the /5 by reciprocal multiply
    assign recip_prod = 29'(len_eff_next[LEN_W-1:2]) * 29'(RECIP5);
    assign n20_next   = N20_W'(recip_prod >> RECIP5_SHIFT);
    assign n20_x20    = LEN_W'({n20_next, 4'b0000}) + LEN_W'({n20_next, 2'b00});
    assign rem20      = 5'(len_eff_next - n20_x20);
    assign r4_next    = rem20[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 3'(MODE_FOUR_PLAIN);
            rows_reg     <= RCNT_W'(1);
            len_reg      <= LEN_W'(4);
            thr_reg      <= THR_W'(898037693);
            rows_eff_reg <= RCNT_W'(1);
            len_eff_reg  <= LEN_W'(4);
            n20_reg      <= '0;
            r4_reg       <= 3'd1;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_LAYOUT_MODE:
                begin
                    mode_reg <= pwdata[2:0];
                end
                REG_ROW_COUNT:
                begin
                    rows_reg     <= rows_in;
                    rows_eff_reg <= rows_eff_next;
                end
                REG_ROW_LENGTH:
                begin
                    len_reg     <= len_in;
                    len_eff_reg <= len_eff_next;
                    n20_reg     <= n20_next;
                    r4_reg      <= r4_next;
                end
                REG_ZERO_THRESHOLD:
                begin
                    thr_reg <= pwdata[THR_W-1:0];
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LAYOUT_MODE:    prdata = 32'(mode_reg);
            REG_ROW_COUNT:      prdata = 32'(rows_reg);
            REG_ROW_LENGTH:     prdata = 32'(len_reg);
            REG_ZERO_THRESHOLD: prdata = 32'(thr_reg);
        endcase
    end

    // unused layout codes fall back to four-trit plain
    always_comb
    begin
        unique case (mode_reg)
            3'(MODE_FOUR_X4):    mode_eff = MODE_FOUR_X4;
            3'(MODE_FOUR_X8):    mode_eff = MODE_FOUR_X8;
            3'(MODE_FIVE_PLAIN): mode_eff = MODE_FIVE_PLAIN;
            3'(MODE_FIVE_X2):    mode_eff = MODE_FIVE_X2;
            default:             mode_eff = MODE_FOUR_PLAIN;
        endcase
    end

    assign n5_all = {n20_reg, 2'b00};

    always_comb
    begin
        cfg.mode      = mode_eff;
        cfg.five      = (mode_eff == MODE_FIVE_PLAIN) || (mode_eff == MODE_FIVE_X2);
        cfg.rows      = rows_eff_reg;
        cfg.len       = len_eff_reg;
        cfg.covered   = {len_eff_reg[LEN_W-1:2], 2'b00};
        cfg.n5        = cfg.five ? n5_all : '0;
        cfg.total     = cfg.five ? (GRP_W'(n5_all) + GRP_W'(r4_reg))
                                 : GRP_W'(len_eff_reg[LEN_W-1:2]);
        cfg.threshold = thr_reg;
    end

endmodule

// ===== hdl/twp_core.sv =====
// ---------------------------------------------------------------------------
// twp_core
// Trit mapping, base-3 accumulate, row/group counters, address and result reg.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module twp_core
    import twp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    input  logic [31:0]       in_bits,
    output logic              take,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [7:0]        out_byte,
    output logic [ADDR_W-1:0] out_addr,
    output logic              out_last
);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [GRP_W-1:0]  grp_reg, grp_next;
    logic [2:0]        pos_reg, pos_next;
    logic [7:0]        acc_reg, acc_next;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_last_reg;

    logic [THR_W-1:0]  mag;
    trit_t             trit;
    logic [7:0]        p3, term, acc_sum;
    logic              active, in_five, close, emit, row_end, last_row, last_grp;
    logic [3:0]        pos_inc;
    logic [1:0]        shift;
    logic [GRP_W-1:0]  g_hi, g_lo;
    logic [25:0]       prod;
    logic [ADDR_W-1:0] addr;

    assign take = in_valid && (!out_valid_reg || out_ready);

    // NaN always maps to zero; infinities go through the compare
    assign mag = in_bits[30:0];
    always_comb
    begin
        if ((mag > FP_INF_MAG) || (mag <= cfg.threshold))
            trit = TRIT_ZERO;
        else if (in_bits[31])
            trit = TRIT_NEG;
        else
            trit = TRIT_POS;
    end

    assign p3 = pow3(pos_reg);
    always_comb
    begin
        unique case (trit)
            TRIT_POS:  term = {p3[6:0], 1'b0};
            TRIT_ZERO: term = p3;
            default:   term = 8'd0;
        endcase
    end
    assign acc_sum = acc_reg + term;

    assign active   = LEN_W'(col_reg) < cfg.covered;
    assign in_five  = grp_reg < GRP_W'(cfg.n5);
    assign pos_inc  = 4'(pos_reg) + 4'd1;
    assign close    = in_five ? (pos_inc >= 4'd5) : (pos_inc >= 4'd4);
    assign emit     = active && close;
    assign row_end  = (LEN_W'(col_reg) + LEN_W'(1)) >= cfg.len;
    assign last_row = (RCNT_W'(row_reg) + RCNT_W'(1)) >= cfg.rows;
    assign last_grp = (14'(grp_reg) + 14'd1) == 14'(cfg.total);

    // interleave: addr = ((g >> s) * R << s) + (j << s) + g[s-1:0]
    always_comb
    begin
        unique case (cfg.mode)
            MODE_FOUR_X4: shift = 2'd2;
            MODE_FOUR_X8: shift = 2'd3;
            MODE_FIVE_X2: shift = in_five ? 2'd1 : 2'd0;
            default:      shift = 2'd0;
        endcase
    end

    assign g_hi = grp_reg >> shift;
    assign g_lo = grp_reg & GRP_W'((GRP_W'(1) << shift) - GRP_W'(1));
    assign prod = 26'(g_hi) * 26'(cfg.rows);
    assign addr = (ADDR_W'(prod) << shift) + (ADDR_W'(row_reg) << shift) + ADDR_W'(g_lo);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        grp_next = grp_reg;
        pos_next = pos_reg;
        acc_next = acc_reg;
        if (take)
        begin
            if (active)
            begin
                if (close)
                begin
                    acc_next = '0;
                    pos_next = '0;
                    grp_next = grp_reg + GRP_W'(1);
                end
                else
                begin
                    acc_next = acc_sum;
                    pos_next = pos_reg + 3'd1;
                end
            end
            if (row_end)
            begin
                col_next = '0;
                grp_next = '0;
                pos_next = '0;
                acc_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            grp_reg       <= '0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            grp_reg <= grp_next;
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            if (take && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_byte_reg <= acc_sum;
            out_addr_reg <= addr;
            out_last_reg <= last_row && last_grp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_addr  = out_addr_reg;
    assign out_last  = out_last_reg;

    `TWP_ASSERT(a_row_restart, clk, rst_n, (take && row_end) |=> (col_reg == '0 && grp_reg == '0 && pos_reg == '0), "row end did not clear counters")
    `TWP_ASSERT(a_row_start_clean, clk, rst_n, (col_reg == '0) |-> (pos_reg == '0 && acc_reg == '0), "partial group at row start")
    `TWP_ASSERT_NEVER(a_acc_range, clk, rst_n, (acc_reg > 8'd242) || (pos_reg > 3'd4), "accumulator or trit position out of range")
    `TWP_ASSERT(a_emit_loads, clk, rst_n, (take && emit) |=> out_valid_reg, "result lost on emit")

endmodule

// ===== hdl/ternary_weight_packer.sv =====
// ---------------------------------------------------------------------------
// ternary_weight_packer
// Maps fp32 weights to trits and packs them base 3 into addressed bytes.
// ---------------------------------------------------------------------------
// channel   dir  handshake                   payload
// s_axis    in   tvalid/tready               tdata = weight_bits
// m_axis    out  tvalid/tready               tdata = packed_byte, dest_addr; tlast = matrix_done
// apb       in   psel/penable/pwrite/pready  4 registers at 0x0, 0x4, 0x8, 0xC
//
// One weight per cycle unless m_axis stalls; a byte's last weight goes through the input
// register and the byte into the result register. The rate is set by the single pass
// from the input register through trit map, group/address logic (one 13x13 multiply)
// into the result register. Reset clears counters and pipeline valids; no clearing pass.
// A stalled result holds the pipe; the input stage still fills behind it.
// ---------------------------------------------------------------------------
module ternary_weight_packer
    import twp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] weight_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] packed_byte, [31:8] dest_addr
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t              cfg;
    logic              in_valid_reg;
    logic [31:0]       in_bits_reg;
    logic              core_take;
    logic [7:0]        out_byte;
    logic [ADDR_W-1:0] out_addr;

    assign s_axis_tready = !in_valid_reg || core_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_bits_reg <= s_axis_tdata;
    end

    twp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    twp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_bits   (in_bits_reg),
        .take      (core_take),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_byte  (out_byte),
        .out_addr  (out_addr),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {out_addr, out_byte};

endmodule
